@@ sv/ths_pkg.sv @@
`default_nettype none

package ths_pkg;

  localparam int CFG_DW  = 64;
  localparam int CFG_AW  = 5;
  localparam int REG_LSB = 3;

  localparam int TOL_W      = 16;
  localparam int REL_SHIFT  = 17;
  localparam logic [TOL_W-1:0] TOL_RESET = 16'd13;

  typedef enum logic [CFG_AW-REG_LSB-1:0] {
    REG_VERTEX_0 = 2'd0,
    REG_VERTEX_1 = 2'd1,
    REG_VERTEX_2 = 2'd2,
    REG_ABS_TOL  = 2'd3
  } reg_idx_t;

endpackage

`default_nettype wire

@@ sv/triangle_height_sampler.sv @@
// channel | dir | handshake          | payload
// in      | in  | in_tvalid/in_tready | in_tdata: point_x, point_z
// out     | out | out_tvalid/out_tready | out_tdata: height; out_tuser: inside_res
// cfg     | in  | psel/penable/pready | paddr, pwdata, pwrite, prdata (64 bit, 8*i)
//
// One point per cycle while in_tready is high; a point passes stages s1..s5, then
// the restoring divider that resolves one quotient bit per stage, then out_tvalid.
// Synchronous active-low reset clears valid bits and loads the register defaults.
// A stalled result moves to a skid register; in_tready drops only while it is full.
// Triangle terms are derived from the registers after a write via tri_*_r, tri_c_r, whole_r, tol_r.
`default_nettype none

module triangle_height_sampler
  import ths_pkg::*;
#(
  parameter int COORD_WIDTH = 16,
  localparam int IN_DW  = ((2*COORD_WIDTH+7)/8)*8,
  localparam int OUT_DW = ((COORD_WIDTH+7)/8)*8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  input  wire logic [IN_DW-1:0]  in_tdata,   // point_x, point_z
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  output logic [OUT_DW-1:0]      out_tdata,  // height
  output logic                   out_tuser,  // inside_res
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [CFG_AW-1:0] paddr,
  input  wire logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int W   = COORD_WIDTH;
  localparam int PW  = 2*W+1;
  localparam int CW  = 2*W+1;
  localparam int SW  = 2*W+3;
  localparam int AW  = 2*W+2;
  localparam int TW  = AW+2;
  localparam int PRW = AW+W+1;
  localparam int NW  = PRW+2;
  localparam int RW  = NW+1;

  // ---------------- configuration registers ----------------
  logic [3*W-1:0]   vertex_r [3];
  logic [TOL_W-1:0] abs_tol_r;
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[CFG_AW-1:REG_LSB]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vertex_r[0] <= '0;
      vertex_r[1] <= '0;
      vertex_r[2] <= '0;
      abs_tol_r   <= TOL_RESET;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_VERTEX_0: vertex_r[0] <= pwdata[3*W-1:0];
        REG_VERTEX_1: vertex_r[1] <= pwdata[3*W-1:0];
        REG_VERTEX_2: vertex_r[2] <= pwdata[3*W-1:0];
        REG_ABS_TOL:  abs_tol_r   <= pwdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_VERTEX_0: prdata = CFG_DW'(vertex_r[0]);
      REG_VERTEX_1: prdata = CFG_DW'(vertex_r[1]);
      REG_VERTEX_2: prdata = CFG_DW'(vertex_r[2]);
      REG_ABS_TOL:  prdata = CFG_DW'(abs_tol_r);
      default:      prdata = '0;
    endcase
  end

  // ---------------- triangle terms ----------------
  logic signed [W-1:0]   vx [3];
  logic signed [W-1:0]   vy [3];
  logic signed [W-1:0]   vz [3];
  logic signed [W:0]     tri_dx_nxt [3];
  logic signed [W:0]     tri_dz_nxt [3];
  logic signed [2*W-1:0] tri_m0_nxt [3];
  logic signed [2*W-1:0] tri_m1_nxt [3];
  logic signed [W:0]     tri_dx_r [3];
  logic signed [W:0]     tri_dz_r [3];
  logic signed [2*W-1:0] tri_m0_r [3];
  logic signed [2*W-1:0] tri_m1_r [3];
  logic signed [CW-1:0]  tri_c_r [3];
  logic signed [SW-1:0]  wsum;
  logic [AW-1:0]         whole_nxt;
  logic [AW-1:0]         whole_r;
  logic [AW-1:0]         whole_rel;
  logic [TW-1:0]         tol_nxt;
  logic [TW-1:0]         tol_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vx[k] = vertex_r[k][W-1:0];
      vy[k] = vertex_r[k][2*W-1:W];
      vz[k] = vertex_r[k][3*W-1:2*W];
    end
    // edge e runs from vertex e to the next one
    for (int e = 0; e < 3; e++) begin
      tri_dx_nxt[e] = (W+1)'(vx[(e == 2) ? 0 : e+1]) - (W+1)'(vx[e]);
      tri_dz_nxt[e] = (W+1)'(vz[e]) - (W+1)'(vz[(e == 2) ? 0 : e+1]);
      tri_m0_nxt[e] = (2*W)'(vx[e]) * (2*W)'(vz[(e == 2) ? 0 : e+1]);
      tri_m1_nxt[e] = (2*W)'(vx[(e == 2) ? 0 : e+1]) * (2*W)'(vz[e]);
    end
    wsum      = SW'(tri_c_r[0]) + SW'(tri_c_r[1]) + SW'(tri_c_r[2]);
    whole_nxt = wsum[SW-1] ? AW'(-wsum) : AW'(wsum);
    whole_rel = whole_r >> REL_SHIFT;
    tol_nxt   = (TW'(whole_rel) < TW'(abs_tol_r)) ? TW'(abs_tol_r) : TW'(whole_rel);
  end

  always_ff @(posedge clk) begin
    for (int e = 0; e < 3; e++) begin
      tri_dx_r[e] <= tri_dx_nxt[e];
      tri_dz_r[e] <= tri_dz_nxt[e];
      tri_m0_r[e] <= tri_m0_nxt[e];
      tri_m1_r[e] <= tri_m1_nxt[e];
      tri_c_r[e]  <= CW'(tri_m0_r[e]) - CW'(tri_m1_r[e]);
    end
    whole_r <= whole_nxt;
    tol_r   <= tol_nxt;
  end

  // ---------------- item pipeline ----------------
  logic                  en;
  logic                  in_acc;
  logic signed [W-1:0]   px;
  logic signed [W-1:0]   pz;

  logic                  s1_v_r;
  logic signed [PW-1:0]  s1_pa_nxt [3];
  logic signed [PW-1:0]  s1_pb_nxt [3];
  logic signed [PW-1:0]  s1_pa_r [3];
  logic signed [PW-1:0]  s1_pb_r [3];

  logic                  s2_v_r;
  logic signed [SW-1:0]  s2_sum [3];
  logic [AW-1:0]         s2_area_nxt [3];
  logic [AW-1:0]         s2_area_r [3];

  logic                  s3_v_r;
  logic [TW-1:0]         s3_total;
  logic signed [TW:0]    s3_dsum_nxt;
  logic signed [TW:0]    s3_dsum_r;
  logic signed [PRW-1:0] s3_prod_nxt [3];
  logic signed [PRW-1:0] s3_prod_r [3];

  logic                  s4_v_r;
  logic [TW-1:0]         s4_dmag;
  logic                  s4_ins_nxt;
  logic                  s4_ins_r;
  logic signed [NW-1:0]  s4_num_nxt;
  logic signed [NW-1:0]  s4_num_r;

  logic                  s5_v_r;
  logic                  s5_ins_r;
  logic                  s5_neg_nxt;
  logic                  s5_neg_r;
  logic [NW-1:0]         s5_mag;
  logic [RW-1:0]         s5_nn_nxt;
  logic [RW-1:0]         s5_nn_r;

  // divider stages; index 0 holds the overflow check
  logic                  dv_r   [W+1];
  logic                  dins_r [W+1];
  logic                  dneg_r [W+1];
  logic                  dovf_r [W+1];
  logic [RW-1:0]         drem_r [W+1];
  logic [W-1:0]          dq_r   [W+1];
  logic [RW-1:0]         drem_nxt [W+1];
  logic [W-1:0]          dq_nxt   [W+1];
  logic [RW-1:0]         dtrial   [W+1];
  logic                  dovf_nxt;

  assign in_acc = in_tvalid && in_tready;
  assign px     = in_tdata[W-1:0];
  assign pz     = in_tdata[2*W-1:W];

  always_comb begin
    for (int e = 0; e < 3; e++) begin
      s1_pa_nxt[e]   = PW'(pz) * PW'(tri_dx_r[e]);
      s1_pb_nxt[e]   = PW'(px) * PW'(tri_dz_r[e]);
      s2_sum[e]      = SW'(tri_c_r[e]) + SW'(s1_pa_r[e]) + SW'(s1_pb_r[e]);
      s2_area_nxt[e] = s2_sum[e][SW-1] ? AW'(-s2_sum[e]) : AW'(s2_sum[e]);
      // sub-area on edge e weights the opposite vertex height
      s3_prod_nxt[e] = PRW'($signed({1'b0, s2_area_r[e]})) *
                       PRW'(vy[(e == 0) ? 2 : e-1]);
    end
    s3_total    = TW'(s2_area_r[0]) + TW'(s2_area_r[1]) + TW'(s2_area_r[2]);
    s3_dsum_nxt = $signed((TW+1)'(s3_total) - (TW+1)'(whole_r));
    s4_dmag     = s3_dsum_r[TW] ? TW'(-s3_dsum_r) : TW'(s3_dsum_r);
    s4_ins_nxt  = (whole_r != '0) && (s4_dmag <= tol_r);
    s4_num_nxt  = NW'(s3_prod_r[0]) + NW'(s3_prod_r[1]) + NW'(s3_prod_r[2]);
    s5_neg_nxt  = s4_num_r[NW-1];
    s5_mag      = s5_neg_nxt ? NW'(-s4_num_r) : NW'(s4_num_r);
    s5_nn_nxt   = RW'(s5_mag) + RW'(whole_r >> 1);
    dovf_nxt    = s5_nn_r >= (RW'(whole_r) << W);
    drem_nxt[0] = '0;
    dq_nxt[0]   = '0;
    dtrial[0]   = '0;
    for (int j = 1; j <= W; j++) begin
      dtrial[j]   = RW'(whole_r) << (W-j);
      drem_nxt[j] = (drem_r[j-1] >= dtrial[j]) ? drem_r[j-1] - dtrial[j] : drem_r[j-1];
      dq_nxt[j]   = {dq_r[j-1][W-2:0], drem_r[j-1] >= dtrial[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
      s5_v_r <= 1'b0;
      for (int j = 0; j <= W; j++) begin
        dv_r[j] <= 1'b0;
      end
    end else if (en) begin
      s1_v_r  <= in_acc;
      s2_v_r  <= s1_v_r;
      s3_v_r  <= s2_v_r;
      s4_v_r  <= s3_v_r;
      s5_v_r  <= s4_v_r;
      dv_r[0] <= s5_v_r;
      for (int j = 1; j <= W; j++) begin
        dv_r[j] <= dv_r[j-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int e = 0; e < 3; e++) begin
        s1_pa_r[e]   <= s1_pa_nxt[e];
        s1_pb_r[e]   <= s1_pb_nxt[e];
        s2_area_r[e] <= s2_area_nxt[e];
        s3_prod_r[e] <= s3_prod_nxt[e];
      end
      s3_dsum_r <= s3_dsum_nxt;
      s4_ins_r  <= s4_ins_nxt;
      s4_num_r  <= s4_num_nxt;
      s5_ins_r  <= s4_ins_r;
      s5_neg_r  <= s5_neg_nxt;
      s5_nn_r   <= s5_nn_nxt;
      dins_r[0] <= s5_ins_r;
      dneg_r[0] <= s5_neg_r;
      dovf_r[0] <= dovf_nxt;
      drem_r[0] <= s5_nn_r;
      dq_r[0]   <= dq_nxt[0];
      for (int j = 1; j <= W; j++) begin
        dins_r[j] <= dins_r[j-1];
        dneg_r[j] <= dneg_r[j-1];
        dovf_r[j] <= dovf_r[j-1];
        drem_r[j] <= drem_nxt[j];
        dq_r[j]   <= dq_nxt[j];
      end
    end
  end

  // ---------------- saturation and output ----------------
  localparam logic [W-1:0] HMAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] HMIN = {1'b1, {(W-1){1'b0}}};

  logic         res_sat;
  logic [W-1:0] res_height;
  logic         push;

  logic         out_v_r;
  logic [W-1:0] out_height_r;
  logic         out_ins_r;
  logic         sk_v_r;
  logic [W-1:0] sk_height_r;
  logic         sk_ins_r;

  always_comb begin
    if (dneg_r[W]) begin
      res_sat    = dovf_r[W] || (dq_r[W] > HMIN);
      res_height = res_sat ? HMIN : W'(-dq_r[W]);
    end else begin
      res_sat    = dovf_r[W] || (dq_r[W] > HMAX);
      res_height = res_sat ? HMAX : dq_r[W];
    end
    if (!dins_r[W]) begin
      res_height = '0;
    end
  end

  assign en        = !sk_v_r;
  assign in_tready = en;
  assign push      = en && dv_r[W];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
      sk_v_r  <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (sk_v_r) begin
        out_v_r <= 1'b1;
        sk_v_r  <= 1'b0;
      end else begin
        out_v_r <= push;
      end
    end else if (push) begin
      sk_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_v_r || out_tready) begin
      if (sk_v_r) begin
        out_height_r <= sk_height_r;
        out_ins_r    <= sk_ins_r;
      end else if (push) begin
        out_height_r <= res_height;
        out_ins_r    <= dins_r[W];
      end
    end else if (push) begin
      sk_height_r <= res_height;
      sk_ins_r    <= dins_r[W];
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = OUT_DW'(out_height_r);
  assign out_tuser  = out_ins_r;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    sk_v_r |-> out_v_r)
    else $error("skid beat held without an output beat");

  a_ready_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(in_tready) |-> $past(out_v_r && !out_tready))
    else $error("input stalled without an output stall");

  a_outside_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_height_r == '0))
    else $error("outside beat with nonzero height");

  a_degenerate: assert property (@(posedge clk) disable iff (!rst_n)
    (s5_v_r && s5_ins_r) |-> (whole_r != '0))
    else $error("inside flag set for a degenerate triangle");
`endif

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps

module tb;
  import ths_pkg::*;

  localparam int CW          = 16;
  localparam int IN_W        = 2 * CW;
  localparam int LATENCY     = CW + 7;
  localparam int SETTLE      = 8;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 9;
  localparam int PHASE_PTS   = 145;
  localparam longint HMAX    = (64'd1 << (CW - 1)) - 1;

  typedef struct packed {
    logic [CW-1:0] height;
    logic          ins;
  } height_res_t;

  typedef enum logic { ROW_WR, ROW_PT } row_kind_t;

  typedef struct packed {
    row_kind_t     kind;
    reg_idx_t      idx;
    logic [63:0]   value;
    logic [CW-1:0] px;
    logic [CW-1:0] pz;
    logic          known;
    height_res_t   res;
  } stim_row_t;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_tvalid;
  logic              in_tready;
  logic [IN_W-1:0]   in_tdata;   // point_x, point_z
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [CW-1:0]     out_tdata;  // height
  logic              out_tuser;  // inside_res
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  logic [3*CW-1:0] vtx_m [3];
  logic [TOL_W-1:0] tol_m;
  height_res_t     height_q [$];
  height_res_t     want;
  stim_row_t       dir_tab [$];
  logic            steady = 1'b0;
  int              errors = 0;
  int              cycles = 0;

  triangle_height_sampler DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #4 clk = ~clk;

  task automatic flag_mismatch(string msg);
    $display("MISMATCH @%0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic longint sx(logic [CW-1:0] v);
    return longint'($signed(v));
  endfunction

  // doubled absolute XZ area
  function automatic longint tri_area2(longint ax, longint az, longint bx, longint bz,
                                       longint cx, longint cz);
    longint s;
    s = ax * (bz - cz) + bx * (cz - az) + cx * (az - bz);
    return (s < 0) ? -s : s;
  endfunction

  function automatic height_res_t sample_height(logic [CW-1:0] px_b, logic [CW-1:0] pz_b);
    longint x [3];
    longint y [3];
    longint z [3];
    longint px, pz, a01, a12, a20, whole, diff, lim, num;
    logic [63:0] mag, w, q;
    height_res_t r;
    for (int k = 0; k < 3; k++) begin
      x[k] = sx(vtx_m[k][CW-1:0]);
      y[k] = sx(vtx_m[k][2*CW-1:CW]);
      z[k] = sx(vtx_m[k][3*CW-1:2*CW]);
    end
    px = sx(px_b);
    pz = sx(pz_b);
    a01 = tri_area2(x[0], z[0], x[1], z[1], px, pz);
    a12 = tri_area2(x[1], z[1], x[2], z[2], px, pz);
    a20 = tri_area2(x[2], z[2], x[0], z[0], px, pz);
    whole = tri_area2(x[0], z[0], x[1], z[1], x[2], z[2]);
    diff = a01 + a12 + a20 - whole;
    if (diff < 0) diff = -diff;
    lim = whole >>> REL_SHIFT;
    if (lim < longint'(tol_m)) lim = longint'(tol_m);
    r = '0;
    if (whole != 0 && diff <= lim) begin
      r.ins = 1'b1;
      num = a01 * y[2] + a12 * y[0] + a20 * y[1];
      mag = (num < 0) ? -num : num;
      w = whole;
      q = (mag + w / 2) / w;
      if (num < 0) begin
        r.height = (q > HMAX + 1) ? {1'b1, {(CW-1){1'b0}}} : CW'(64'd0 - q);
      end else begin
        r.height = (q > HMAX) ? {1'b0, {(CW-1){1'b1}}} : q[CW-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic [63:0] reg_mirror(reg_idx_t idx);
    if (idx == REG_ABS_TOL) return 64'(tol_m);
    return 64'(vtx_m[int'(idx)]);
  endfunction

  function automatic logic [63:0] vtx_word(int x, int y, int z);
    return {16'h0, CW'(z), CW'(y), CW'(x)};
  endfunction

  function automatic stim_row_t wr_row(reg_idx_t idx, logic [63:0] value);
    stim_row_t r;
    r = '0;
    r.kind = ROW_WR;
    r.idx = idx;
    r.value = value;
    return r;
  endfunction

  function automatic stim_row_t pt_row(int px, int pz, logic known, int h, logic ins);
    stim_row_t r;
    r = '0;
    r.kind = ROW_PT;
    r.px = CW'(px);
    r.pz = CW'(pz);
    r.known = known;
    r.res.height = CW'(h);
    r.res.ins = ins;
    return r;
  endfunction

  function automatic void add_row(stim_row_t r);
    dir_tab = {dir_tab, r};
  endfunction

  task automatic cfg_write(reg_idx_t idx, logic [63:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_AW'(idx) << REG_LSB;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic cfg_read(reg_idx_t idx, output logic [63:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= CFG_AW'(idx) << REG_LSB;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (height_q.size() != 0) @(negedge clk);
    repeat (LATENCY) @(negedge clk);
  endtask

  task automatic load_reg(reg_idx_t idx, logic [63:0] value);
    logic [63:0] rd;
    drain_results();
    cfg_write(idx, value);
    if (idx == REG_ABS_TOL) tol_m = value[TOL_W-1:0];
    else vtx_m[int'(idx)] = value[3*CW-1:0];
    cfg_read(idx, rd);
    if (rd !== reg_mirror(idx))
      flag_mismatch($sformatf("reg %s read %h want %h", idx.name(), rd, reg_mirror(idx)));
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic send_point(logic [CW-1:0] px, logic [CW-1:0] pz, logic known,
                            height_res_t res);
    while (!steady && $urandom_range(0, 99) < 38) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {pz, px};
    do @(posedge clk); while (!in_tready);
    height_q = {height_q, known ? res : sample_height(px, pz)};
    @(negedge clk);
  endtask

  always @(negedge clk) out_tready <= steady || ($urandom_range(0, 99) >= 38);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (height_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat height %h inside %b", out_tdata, out_tuser));
      end else begin
        want = height_q.pop_front();
        if (out_tdata !== want.height)
          flag_mismatch($sformatf("height %h want %h", out_tdata, want.height));
        if (out_tuser !== want.ins)
          flag_mismatch($sformatf("inside %b want %b", out_tuser, want.ins));
      end
    end
  end

  initial begin
    int sel, w0, w1, w2, s, px, pz, cx, cz, dx, dz, tsel;
    int vx [3];
    int vy [3];
    int vz [3];
    logic [63:0] rd;
    logic [TOL_W-1:0] tolv;

    in_tvalid = 1'b0;
    in_tdata = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rst_n = 1'b0;
    for (int k = 0; k < 3; k++) vtx_m[k] = '0;
    tol_m = TOL_RESET;

    // reset triangle is degenerate
    add_row(pt_row(0, 0, 1, 0, 0));
    add_row(pt_row('h7fff, 'h7fff, 1, 0, 0));
    add_row(pt_row('h8000, 'h8000, 1, 0, 0));
    // right triangle in the positive quadrant
    add_row(wr_row(REG_VERTEX_0, vtx_word(0, 'h100, 0)));
    add_row(wr_row(REG_VERTEX_1, vtx_word('h1000, 'h200, 0)));
    add_row(wr_row(REG_VERTEX_2, vtx_word(0, 'h300, 'h1000)));
    add_row(pt_row(0, 0, 1, 'h100, 1));
    add_row(pt_row('h1000, 0, 1, 'h200, 1));
    add_row(pt_row(0, 'h1000, 1, 'h300, 1));
    add_row(pt_row('h400, 'h400, 0, 0, 0));
    add_row(pt_row('h800, 'h800, 0, 0, 0));
    add_row(pt_row('h7fff, 'h7fff, 1, 0, 0));
    add_row(pt_row('h8000, 'h8000, 1, 0, 0));
    add_row(pt_row('h8000, 'h7fff, 1, 0, 0));
    add_row(pt_row('h7fff, 'h8000, 1, 0, 0));
    // zero tolerance, on and just off the hypotenuse
    add_row(wr_row(REG_ABS_TOL, 64'h0));
    add_row(pt_row('h800, 'h800, 0, 0, 0));
    add_row(pt_row('h801, 'h800, 0, 0, 0));
    // full-range triangle, excess register bits set
    add_row(wr_row(REG_VERTEX_0,
                   vtx_word('h8000, 'h8000, 'h8000) | 64'hffff_0000_0000_0000));
    add_row(wr_row(REG_VERTEX_1,
                   vtx_word('h7fff, 'h7fff, 'h8000) | 64'hffff_0000_0000_0000));
    add_row(wr_row(REG_VERTEX_2,
                   vtx_word('h8000, 'h7fff, 'h7fff) | 64'hffff_0000_0000_0000));
    add_row(wr_row(REG_ABS_TOL, 64'hffff_ffff_ffff_ffff));
    add_row(pt_row('h8000, 'h8000, 1, 'h8000, 1));
    add_row(pt_row('h7fff, 'h8000, 1, 'h7fff, 1));
    add_row(pt_row(0, 0, 0, 0, 0));
    add_row(pt_row('h7fff, 'h7fff, 1, 0, 0));
    // tiny triangle, wide tolerance: height saturates both ways
    add_row(wr_row(REG_VERTEX_0, vtx_word(0, 'h7fff, 0)));
    add_row(wr_row(REG_VERTEX_1, vtx_word(1, 'h7fff, 0)));
    add_row(wr_row(REG_VERTEX_2, vtx_word(0, 'h7fff, 1)));
    add_row(pt_row(2, 2, 1, 'h7fff, 1));
    add_row(pt_row(0, 0, 1, 'h7fff, 1));
    add_row(wr_row(REG_VERTEX_0, vtx_word(0, 'h8000, 0)));
    add_row(wr_row(REG_VERTEX_1, vtx_word(1, 'h8000, 0)));
    add_row(wr_row(REG_VERTEX_2, vtx_word(0, 'h8000, 1)));
    add_row(pt_row(2, 2, 1, 'h8000, 1));
    add_row(pt_row(0, 0, 0, 0, 0));
    // collinear vertices
    add_row(wr_row(REG_VERTEX_0, vtx_word(0, 'h100, 0)));
    add_row(wr_row(REG_VERTEX_1, vtx_word('h100, 'h200, 'h100)));
    add_row(wr_row(REG_VERTEX_2, vtx_word('h200, 'h300, 'h200)));
    add_row(pt_row('h100, 'h100, 1, 0, 0));
    add_row(pt_row(0, 0, 1, 0, 0));

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int k = 0; k < 4; k++) begin
      cfg_read(reg_idx_t'(k), rd);
      if (rd !== reg_mirror(reg_idx_t'(k)))
        flag_mismatch($sformatf("reset value of reg %0d is %h", k, rd));
    end

    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_WR) begin
        load_reg(dir_tab[i].idx, dir_tab[i].value);
      end else begin
        send_point(dir_tab[i].px, dir_tab[i].pz, dir_tab[i].known, dir_tab[i].res);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int k = 0; k < 3; k++) begin
        case (ph % 4)
          0: begin
            vx[k] = $urandom_range(0, 65535) - 32768;
            vz[k] = $urandom_range(0, 65535) - 32768;
          end
          1: begin
            if (k == 0) begin
              cx = $urandom_range(0, 60000) - 30000;
              cz = $urandom_range(0, 60000) - 30000;
            end
            vx[k] = cx + $urandom_range(0, 2048) - 1024;
            vz[k] = cz + $urandom_range(0, 2048) - 1024;
          end
          2: begin
            if (k == 0) begin
              vx[0] = $urandom_range(0, 20000) - 10000;
              vz[0] = $urandom_range(0, 20000) - 10000;
              dx = $urandom_range(0, 2000) - 1000;
              dz = $urandom_range(0, 2000) - 1000;
            end
            vx[k] = vx[0] + k * dx;
            vz[k] = vz[0] + k * dz;
          end
          default: begin
            vx[k] = $urandom_range(0, 1) ? 32767 : -32768;
            vz[k] = $urandom_range(0, 1) ? 32767 : -32768;
          end
        endcase
        vy[k] = $urandom_range(0, 65535) - 32768;
      end
      tsel = (ph + 1) % 4;
      case (tsel)
        0: tolv = '0;
        1: tolv = '1;
        2: tolv = TOL_RESET;
        default: tolv = TOL_W'($urandom_range(0, 65535));
      endcase
      for (int k = 0; k < 3; k++)
        load_reg(reg_idx_t'(k),
                 {16'($urandom), CW'(vz[k]), CW'(vy[k]), CW'(vx[k])});
      load_reg(REG_ABS_TOL, {48'($urandom), tolv});

      steady = (ph == 4);
      for (int n = 0; n < PHASE_PTS; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
          w0 = $urandom_range(0, 255);
          w1 = $urandom_range(0, 255);
          w2 = $urandom_range(0, 255);
          s = w0 + w1 + w2;
          if (s == 0) s = 1;
          px = (w0 * vx[0] + w1 * vx[1] + w2 * vx[2]) / s;
          pz = (w0 * vz[0] + w1 * vz[1] + w2 * vz[2]) / s;
        end else if (sel < 75) begin
          w0 = $urandom_range(0, 2);
          px = vx[w0] + $urandom_range(0, 6) - 3;
          pz = vz[w0] + $urandom_range(0, 6) - 3;
        end else begin
          px = $urandom_range(0, 65535);
          pz = $urandom_range(0, 65535);
        end
        send_point(CW'(px), CW'(pz), 1'b0, '0);
      end
      steady = 1'b0;
    end

    drain_results();
    if (height_q.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", height_q.size()));
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule
